// ===== rtl/tpid_pkg.sv =====
// ----------------------------------------------------------------------------
// tpid_pkg
// Shared widths, register indexes and reset values of the three-axis PID
// attitude tracker.
// ----------------------------------------------------------------------------
package tpid_pkg;

  localparam int NUM_AXES   = 3;
  localparam int DATA_W     = 16;   // Q4.12 angles, rates, drives; Q0.16 dt
  localparam int GAIN_W     = 48;   // kp, kd, ki packed, Q8.8 each
  localparam int COEF_W     = 16;
  localparam int REG_W      = 15;   // windows and limits
  localparam int INTEG_W    = 32;   // Q8.24 integral
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAIN_W;

  localparam int YAW_AXIS   = 2;

  typedef logic signed [DATA_W-1:0]  q4_12_t;
  typedef logic signed [INTEG_W-1:0] integ_t;

  localparam logic [CFG_IDX_W-1:0] REG_GAINS_ROLL        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAINS_PITCH       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAINS_YAW         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_ROLL_PITCH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_YAW        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ROLL        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_PITCH       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_YAW         = 3'd7;

  localparam logic [REG_W-1:0] WINDOW_RP_RST = 15'd614;
  localparam logic [REG_W-1:0] WINDOW_Y_RST  = 15'd2048;
  localparam logic [REG_W-1:0] LIMIT_RST     = 15'd4096;

  localparam integ_t INTEG_MAX = 32'sh7FFF_FFFF;
  localparam integ_t INTEG_MIN = 32'sh8000_0000;

endpackage

// ===== rtl/three_axis_pid_attitude_tracker_top.sv =====
// ----------------------------------------------------------------------------
// three_axis_pid_attitude_tracker_top
// Per-axis PID with command window, drive saturation and saturating integral.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one control tick: commanded
//   angle, measured angle and rate per axis plus step_time. Output channel
//   (out_valid / out_stall) returns one transfer of three saturated drives.
//   A tick passes one input register, then the full PID evaluation in front
//   of the result register; out_valid rises when the result register takes
//   it, and the drives can transfer while out_valid is high.
//   Throughput is one tick per cycle; the integral of each axis is updated
//   in the same cycle its drive is registered, so back-to-back ticks see it.
//   When the receiver stalls, the result register holds; one more tick can
//   wait in the input register, after which in_stall rises.
//   Reset clears both valid flags and the integrals, and loads gains 0,
//   windows 614 / 2048 and limits 4096. Configuration writes (cfg_write,
//   cfg_index, cfg_data) are to be made only while no tick is in flight, which
//   the block does not enforce. Axes at or above AXES output a drive of zero.
// ----------------------------------------------------------------------------
module three_axis_pid_attitude_tracker_top
  import tpid_pkg::*;
#(
  parameter int AXES = NUM_AXES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [15:0]     cmd_roll,
  input  logic signed [15:0]     cmd_pitch,
  input  logic signed [15:0]     cmd_yaw,
  input  logic signed [15:0]     angle_roll,
  input  logic signed [15:0]     angle_pitch,
  input  logic signed [15:0]     angle_yaw,
  input  logic signed [15:0]     rate_roll,
  input  logic signed [15:0]     rate_pitch,
  input  logic signed [15:0]     rate_yaw,
  input  logic [15:0]            step_time,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [15:0]     drive_roll,
  output logic signed [15:0]     drive_pitch,
  output logic signed [15:0]     drive_yaw
);

  logic [GAIN_W-1:0] gains [NUM_AXES];
  logic [REG_W-1:0]  limits [NUM_AXES];
  logic [REG_W-1:0]  window_rp;
  logic [REG_W-1:0]  window_y;

  logic              s1_valid;
  q4_12_t            s1_cmd   [NUM_AXES];
  q4_12_t            s1_angle [NUM_AXES];
  q4_12_t            s1_rate  [NUM_AXES];
  logic [DATA_W-1:0] s1_step;

  q4_12_t            drive_next [NUM_AXES];
  q4_12_t            drive      [NUM_AXES];
  logic              advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        gains[a]  <= '0;
        limits[a] <= LIMIT_RST;
      end
      window_rp <= WINDOW_RP_RST;
      window_y  <= WINDOW_Y_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GAINS_ROLL:        gains[0]  <= cfg_data;
        REG_GAINS_PITCH:       gains[1]  <= cfg_data;
        REG_GAINS_YAW:         gains[2]  <= cfg_data;
        REG_WINDOW_ROLL_PITCH: window_rp <= cfg_data[REG_W-1:0];
        REG_WINDOW_YAW:        window_y  <= cfg_data[REG_W-1:0];
        REG_LIMIT_ROLL:        limits[0] <= cfg_data[REG_W-1:0];
        REG_LIMIT_PITCH:       limits[1] <= cfg_data[REG_W-1:0];
        REG_LIMIT_YAW:         limits[2] <= cfg_data[REG_W-1:0];
      endcase
    end
  end

  // result register moves when empty or when its transfer completes
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_cmd[0]   <= cmd_roll;
      s1_cmd[1]   <= cmd_pitch;
      s1_cmd[2]   <= cmd_yaw;
      s1_angle[0] <= angle_roll;
      s1_angle[1] <= angle_pitch;
      s1_angle[2] <= angle_yaw;
      s1_rate[0]  <= rate_roll;
      s1_rate[1]  <= rate_pitch;
      s1_rate[2]  <= rate_yaw;
      s1_step     <= step_time;
    end
  end

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
    if (i < AXES) begin : g_used
      localparam logic signed [49:0] DRV_HALF = 50'sd524288;   // 2^19
      localparam logic signed [33:0] INT_HALF = 34'sd8;        // 2^3

      integ_t              integ;
      integ_t              integ_next;
      logic [REG_W-1:0]    win;
      logic signed [17:0]  ang_x, cmd_x, win_x, hi, lo, clamped, err_x;
      logic signed [16:0]  err;
      logic signed [33:0]  p_kp;
      logic signed [32:0]  p_kd;
      logic signed [48:0]  p_ki;
      logic signed [49:0]  sum, rnd;
      logic signed [29:0]  scaled, lim_x;
      logic signed [33:0]  p_dt, p_dt_rnd;
      logic signed [29:0]  inc;
      logic signed [32:0]  integ_sum;

      assign win   = (i == YAW_AXIS) ? window_y : window_rp;
      assign ang_x = {{2{s1_angle[i][15]}}, s1_angle[i]};
      assign cmd_x = {{2{s1_cmd[i][15]}}, s1_cmd[i]};
      assign win_x = $signed({3'b000, win});
      assign hi    = ang_x + win_x;
      assign lo    = ang_x - win_x;

      always_comb begin
        priority if (cmd_x > hi) begin
          clamped = hi;
        end else if (cmd_x < lo) begin
          clamped = lo;
        end else begin
          clamped = cmd_x;
        end
      end

      // |err| <= window, so 17 bits hold it
      assign err_x = clamped - ang_x;
      assign err   = err_x[16:0];

      assign p_kp = $signed({1'b0, gains[i][15:0]}) * err;
      assign p_kd = $signed({1'b0, gains[i][31:16]}) * s1_rate[i];
      assign p_ki = $signed({1'b0, gains[i][47:32]}) * integ;

      // Q.32 sum, round half up, down to Q4.12
      assign sum = $signed({{4{p_kp[33]}}, p_kp, 12'b0})
                 - $signed({{5{p_kd[32]}}, p_kd, 12'b0})
                 + $signed({p_ki[48], p_ki});
      assign rnd    = sum + DRV_HALF;
      assign scaled = rnd[49:20];
      assign lim_x  = $signed({15'b0, limits[i]});

      always_comb begin
        priority if (scaled > lim_x) begin
          drive_next[i] = lim_x[15:0];
        end else if (scaled < -lim_x) begin
          drive_next[i] = 16'(-lim_x);
        end else begin
          drive_next[i] = scaled[15:0];
        end
      end

      // integral step: error*dt in Q.28, rounded to Q.24, saturated
      assign p_dt      = err * $signed({1'b0, s1_step});
      assign p_dt_rnd  = p_dt + INT_HALF;
      assign inc       = p_dt_rnd[33:4];
      assign integ_sum = {integ[31], integ} + {{3{inc[29]}}, inc};

      always_comb begin
        if (integ_sum[32] != integ_sum[31]) begin
          integ_next = integ_sum[32] ? INTEG_MIN : INTEG_MAX;
        end else begin
          integ_next = integ_sum[31:0];
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          integ <= '0;
        end else if (advance && s1_valid) begin
          integ <= integ_next;
        end
      end
    end else begin : g_unused
      assign drive_next[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        drive[a] <= drive_next[a];
      end
    end
  end

  assign drive_roll  = drive[0];
  assign drive_pitch = drive[1];
  assign drive_yaw   = drive[2];

endmodule

// ===== rtl/tpid_chk.sv =====
// ----------------------------------------------------------------------------
// tpid_chk
// Port-level checks of the PID attitude tracker, bound to its top level.
// ----------------------------------------------------------------------------
module tpid_chk
  import tpid_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   in_valid,
  input logic   in_stall,
  input logic   out_valid,
  input logic   out_stall,
  input q4_12_t drive_roll,
  input q4_12_t drive_pitch,
  input q4_12_t drive_yaw
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // input only backs up when the result side is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without output stall");

  // result register fills behind the input register when the output side keeps up
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("result missing two cycles after input transfer");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(drive_roll) && $stable(drive_pitch) && $stable(drive_yaw)))
    else $error("stalled result changed");

endmodule

bind three_axis_pid_attitude_tracker_top tpid_chk u_tpid_chk (.*);

// ===== verif/tpid_drive_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tpid_drive_checker
// Watches the configuration port and both channels of the attitude tracker.
// It keeps its own copy of the gains, windows, limits and integrals. For each
// input transfer it computes the three saturated drives, and it compares
// every output transfer against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tpid_drive_checker
  import tpid_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  q4_12_t                cmd_roll,
  input  q4_12_t                cmd_pitch,
  input  q4_12_t                cmd_yaw,
  input  q4_12_t                angle_roll,
  input  q4_12_t                angle_pitch,
  input  q4_12_t                angle_yaw,
  input  q4_12_t                rate_roll,
  input  q4_12_t                rate_pitch,
  input  q4_12_t                rate_yaw,
  input  logic [DATA_W-1:0]     step_time,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  q4_12_t                drive_roll,
  input  q4_12_t                drive_pitch,
  input  q4_12_t                drive_yaw,
  output int                    fail_count,
  output int                    outstanding
);

  typedef logic [NUM_AXES-1:0][DATA_W-1:0] drive_vec_t;

  logic [GAIN_W-1:0] gain_reg  [NUM_AXES];
  logic [REG_W-1:0]  limit_reg [NUM_AXES];
  logic [REG_W-1:0]  window_rp_reg;
  logic [REG_W-1:0]  window_y_reg;
  integ_t            integ_acc [NUM_AXES];

  drive_vec_t expected_drives[$];
  int         drives_checked = 0;
  string      axis_name [NUM_AXES] = '{"roll", "pitch", "yaw"};

  // Shift right with round half up; >>> on a signed value floors.
  function automatic longint round_shift(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("%0t ns MISMATCH: %s", $time, msg);
  endtask

  // Drives use the integral from before this tick; the integral moves after.
  task automatic compute_drives(input logic [NUM_AXES-1:0][DATA_W-1:0] cmd_v,
                                input logic [NUM_AXES-1:0][DATA_W-1:0] ang_v,
                                input logic [NUM_AXES-1:0][DATA_W-1:0] rate_v,
                                input logic [DATA_W-1:0] dt,
                                output drive_vec_t d);
    longint cmd, ang, rate, win, lim, err, kp, kd, ki, acc;
    for (int a = 0; a < NUM_AXES; a++) begin
      cmd  = longint'($signed(cmd_v[a]));
      ang  = longint'($signed(ang_v[a]));
      rate = longint'($signed(rate_v[a]));
      win  = (a == YAW_AXIS) ? longint'(window_y_reg) : longint'(window_rp_reg);
      lim  = longint'(limit_reg[a]);
      // the window may reach past the 16-bit range; kept wide here
      err  = clip(cmd, ang - win, ang + win) - ang;
      kp   = longint'(gain_reg[a][COEF_W-1:0]);
      kd   = longint'(gain_reg[a][2*COEF_W-1:COEF_W]);
      ki   = longint'(gain_reg[a][3*COEF_W-1:2*COEF_W]);
      acc  = kp * err * 4096 - kd * rate * 4096 + ki * longint'(integ_acc[a]);
      acc  = clip(round_shift(acc, 20), -lim, lim);
      d[a] = acc[DATA_W-1:0];
      acc  = longint'(integ_acc[a]) + round_shift(err * longint'(dt), 4);
      acc  = clip(acc, longint'(INTEG_MIN), longint'(INTEG_MAX));
      integ_acc[a] = acc[INTEG_W-1:0];
    end
  endtask

  always @(posedge clk) begin
    drive_vec_t got, want, fresh;
    if (rst) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        gain_reg[a]  = '0;
        limit_reg[a] = LIMIT_RST;
        integ_acc[a] = '0;
      end
      window_rp_reg = WINDOW_RP_RST;
      window_y_reg  = WINDOW_Y_RST;
      expected_drives.delete();
      outstanding <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_GAINS_ROLL:        gain_reg[0]   = cfg_data[GAIN_W-1:0];
          REG_GAINS_PITCH:       gain_reg[1]   = cfg_data[GAIN_W-1:0];
          REG_GAINS_YAW:         gain_reg[2]   = cfg_data[GAIN_W-1:0];
          REG_WINDOW_ROLL_PITCH: window_rp_reg = cfg_data[REG_W-1:0];
          REG_WINDOW_YAW:        window_y_reg  = cfg_data[REG_W-1:0];
          REG_LIMIT_ROLL:        limit_reg[0]  = cfg_data[REG_W-1:0];
          REG_LIMIT_PITCH:       limit_reg[1]  = cfg_data[REG_W-1:0];
          REG_LIMIT_YAW:         limit_reg[2]  = cfg_data[REG_W-1:0];
          default: ;
        endcase
      end
      // retire before predicting, so a result can't match a same-edge tick
      if (out_valid && !out_stall) begin
        got = {drive_yaw, drive_pitch, drive_roll};
        if (expected_drives.size() == 0) begin
          report_mismatch($sformatf("drive transfer %0d with no tick pending",
                                    drives_checked));
        end else begin
          want = expected_drives.pop_front();
          for (int a = 0; a < NUM_AXES; a++) begin
            if (got[a] !== want[a])
              report_mismatch($sformatf("transfer %0d %s drive %0d, predicted %0d",
                                        drives_checked, axis_name[a],
                                        $signed(got[a]), $signed(want[a])));
          end
        end
        drives_checked++;
      end
      if (in_valid && !in_stall) begin
        compute_drives({cmd_yaw, cmd_pitch, cmd_roll},
                       {angle_yaw, angle_pitch, angle_roll},
                       {rate_yaw, rate_pitch, rate_roll}, step_time, fresh);
        expected_drives.push_back(fresh);
      end
      outstanding <= expected_drives.size();
    end
  end

endmodule

// ===== verif/three_axis_pid_attitude_tracker_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_axis_pid_attitude_tracker_top_tb
// Stimulus and verdict for the three-axis attitude tracker. A directed run
// covers reset settings, field extremes, integral saturation, windows that
// reach past the field range, zero window and zero limit. Random phases then
// change every register between them and mix idle and stall patterns,
// including one long receiver hold-off. A checker beside the block predicts
// and compares each drive transfer.
// ----------------------------------------------------------------------------
module three_axis_pid_attitude_tracker_top_tb
  import tpid_pkg::*;
;

  localparam int PHASES       = 8;
  localparam int PHASE_TICKS  = 225;
  localparam int HOLD_TICKS   = 30;
  localparam int HOLD_CYCLES  = 120;
  localparam int LIMIT_CYCLES = 200000;

  typedef logic [NUM_AXES-1:0][DATA_W-1:0] axis_vec_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  q4_12_t                cmd_roll, cmd_pitch, cmd_yaw;
  q4_12_t                angle_roll, angle_pitch, angle_yaw;
  q4_12_t                rate_roll, rate_pitch, rate_yaw;
  logic [DATA_W-1:0]     step_time;
  logic                  out_valid;
  logic                  out_stall;
  q4_12_t                drive_roll, drive_pitch, drive_yaw;

  int fail_count;
  int outstanding;
  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int hold_req        = 0;
  int cycle_count     = 0;

  always #6 clk = ~clk;

  three_axis_pid_attitude_tracker_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd_roll    (cmd_roll),
    .cmd_pitch   (cmd_pitch),
    .cmd_yaw     (cmd_yaw),
    .angle_roll  (angle_roll),
    .angle_pitch (angle_pitch),
    .angle_yaw   (angle_yaw),
    .rate_roll   (rate_roll),
    .rate_pitch  (rate_pitch),
    .rate_yaw    (rate_yaw),
    .step_time   (step_time),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .drive_roll  (drive_roll),
    .drive_pitch (drive_pitch),
    .drive_yaw   (drive_yaw)
  );

  tpid_drive_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd_roll    (cmd_roll),
    .cmd_pitch   (cmd_pitch),
    .cmd_yaw     (cmd_yaw),
    .angle_roll  (angle_roll),
    .angle_pitch (angle_pitch),
    .angle_yaw   (angle_yaw),
    .rate_roll   (rate_roll),
    .rate_pitch  (rate_pitch),
    .rate_yaw    (rate_yaw),
    .step_time   (step_time),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .drive_roll  (drive_roll),
    .drive_pitch (drive_pitch),
    .drive_yaw   (drive_yaw),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Receiver: random stall, or a long hold-off when one is requested.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("three_axis_pid_attitude_tracker_top verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Narrow registers get random junk above their width; it must be dropped.
  task automatic program_tracker(input logic [GAIN_W-1:0] g_roll, g_pitch, g_yaw,
                                 input logic [REG_W-1:0] w_rp, w_y,
                                 input logic [REG_W-1:0] l_roll, l_pitch, l_yaw);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'({$urandom, $urandom});
    write_reg(REG_GAINS_ROLL, g_roll);
    write_reg(REG_GAINS_PITCH, g_pitch);
    write_reg(REG_GAINS_YAW, g_yaw);
    write_reg(REG_WINDOW_ROLL_PITCH, {junk[CFG_DATA_W-1:REG_W], w_rp});
    write_reg(REG_WINDOW_YAW, {junk[CFG_DATA_W-1:REG_W], w_y});
    write_reg(REG_LIMIT_ROLL, {junk[CFG_DATA_W-1:REG_W], l_roll});
    write_reg(REG_LIMIT_PITCH, {junk[CFG_DATA_W-1:REG_W], l_pitch});
    write_reg(REG_LIMIT_YAW, {junk[CFG_DATA_W-1:REG_W], l_yaw});
    cfg_write <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic send_tick(input axis_vec_t cmd, input axis_vec_t ang,
                           input axis_vec_t rate, input logic [DATA_W-1:0] dt);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_roll    <= cmd[0];
    cmd_pitch   <= cmd[1];
    cmd_yaw     <= cmd[2];
    angle_roll  <= ang[0];
    angle_pitch <= ang[1];
    angle_yaw   <= ang[2];
    rate_roll   <= rate[0];
    rate_pitch  <= rate[1];
    rate_yaw    <= rate[2];
    step_time   <= dt;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [COEF_W-1:0] gain_field();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2, 3:    return COEF_W'($urandom_range(1023));
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] random_gains();
    return {gain_field(), gain_field(), gain_field()};
  endfunction

  function automatic logic [REG_W-1:0] random_window();
    case ($urandom_range(4))
      0:       return '0;
      1:       return '1;
      default: return REG_W'($urandom_range(8192));
    endcase
  endfunction

  function automatic logic [REG_W-1:0] random_limit();
    case ($urandom_range(4))
      0:       return '0;
      1:       return '1;
      default: return REG_W'($urandom_range(32767, 1));
    endcase
  endfunction

  // drift 1 keeps every error >= 0, drift 2 <= 0, so the integrals
  // run into their saturation bounds; drift 0 is mixed.
  task automatic random_tick(input int drift);
    axis_vec_t cmd, ang, rate;
    logic [DATA_W-1:0] dt;
    for (int a = 0; a < NUM_AXES; a++) begin
      case ($urandom_range(9))
        0:       ang[a] = 16'h8000;
        1:       ang[a] = 16'h7FFF;
        default: ang[a] = 16'($urandom);
      endcase
      case ($urandom_range(8))
        0, 1, 2, 3: cmd[a] = 16'($urandom);
        4, 5, 6, 7: cmd[a] = ang[a] + 16'($urandom_range(4096)) - 16'd2048;
        default:    cmd[a] = $urandom_range(1) ? 16'h7FFF : 16'h8000;
      endcase
      if (drift == 1) begin
        ang[a] = 16'($urandom_range(32767)) | 16'h8000;
        cmd[a] = 16'($urandom_range(32767));
      end else if (drift == 2) begin
        ang[a] = 16'($urandom_range(32767));
        cmd[a] = 16'($urandom_range(32767)) | 16'h8000;
      end
      case ($urandom_range(9))
        0:       rate[a] = 16'h8000;
        1:       rate[a] = 16'h7FFF;
        2:       rate[a] = '0;
        default: rate[a] = 16'($urandom);
      endcase
    end
    case ($urandom_range(7))
      0:       dt = '0;
      1:       dt = '1;
      default: dt = (drift != 0) ? 16'($urandom_range(65535, 32768)) : 16'($urandom);
    endcase
    send_tick(cmd, ang, rate, dt);
  endtask

  initial begin
    int left;
    int run;
    int drift;
    rst         <= 1'b1;
    cfg_write   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    cmd_roll    <= '0;
    cmd_pitch   <= '0;
    cmd_yaw     <= '0;
    angle_roll  <= '0;
    angle_pitch <= '0;
    angle_yaw   <= '0;
    rate_roll   <= '0;
    rate_pitch  <= '0;
    rate_yaw    <= '0;
    step_time   <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Gains only, so windows and limits still hold their reset values.
    write_reg(REG_GAINS_ROLL, {16'h0200, 16'h0080, 16'h0100});
    write_reg(REG_GAINS_PITCH, {16'h0200, 16'h0080, 16'h0100});
    write_reg(REG_GAINS_YAW, {16'h0200, 16'h0080, 16'h0100});
    cfg_write <= 1'b0;
    send_tick({3{16'h7FFF}}, '0, '0, 16'hFFFF);
    send_tick({3{16'h8000}}, '0, {3{16'h8000}}, 16'hFFFF);
    send_tick({3{16'd100}}, '0, {3{16'h7FFF}}, '0);
    in_valid <= 1'b0;
    wait_drained();

    // Widest windows reach past the field range; integral runs to its maximum.
    program_tracker({3{16'h0001}}, {3{16'h0001}}, {3{16'h0001}},
                    '1, '1, '1, '1, '1);
    repeat (17) send_tick({3{16'h7FFF}}, {3{16'h8000}}, '0, 16'hFFFF);
    send_tick({3{16'h8000}}, {3{16'h7FFF}}, {3{16'h7FFF}}, '0);
    send_tick({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, 16'hFFFF);
    in_valid <= 1'b0;
    wait_drained();

    // Zero window on roll/pitch, zero limit on roll, limit of one on yaw.
    program_tracker({16'h0040, 16'h0100, 16'h0300}, {16'h0040, 16'h0100, 16'h0300},
                    {16'h0040, 16'h0100, 16'h0300}, '0, '1, '0, '1, 15'd1);
    send_tick({3{16'd20000}}, {3{-16'sd5000}}, {3{16'd1234}}, 16'd40000);
    send_tick({3{16'h8000}}, {3{16'h7FFF}}, {3{16'h8000}}, 16'hFFFF);
    in_valid <= 1'b0;
    wait_drained();

    // Long receiver hold-off while ticks keep coming: the block backs up.
    program_tracker(random_gains(), random_gains(), random_gains(),
                    random_window(), random_window(),
                    random_limit(), random_limit(), random_limit());
    hold_req = hold_req + 1;
    repeat (HOLD_TICKS) random_tick(0);
    in_valid <= 1'b0;
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      sender_idle_pct = 0;
      stall_pct       = 0;
      if (p == 1)
        program_tracker('1, '1, '1, '1, '1, '1, '1, '1);
      else if (p == 2)
        program_tracker('0, '0, '0, '0, '0, '0, '0, '0);
      else
        program_tracker(random_gains(), random_gains(), random_gains(),
                        random_window(), random_window(),
                        random_limit(), random_limit(), random_limit());
      case (p % 4)
        1:       sender_idle_pct = 63;
        2:       stall_pct = 63;
        3: begin
          sender_idle_pct = 37;
          stall_pct       = 37;
        end
        default: ;
      endcase
      left = PHASE_TICKS;
      while (left > 0) begin
        run   = $urandom_range(40, 5);
        drift = ($urandom_range(2) == 0) ? $urandom_range(2, 1) : 0;
        if (run > left) run = left;
        repeat (run) random_tick(drift);
        left -= run;
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (fail_count == 0)
      $display("three_axis_pid_attitude_tracker_top verification clean");
    else
      $display("three_axis_pid_attitude_tracker_top verification failed");
    $finish;
  end

endmodule
